// File: sv/mli_pkg.sv
// shared types and constants for the mean line intersection core
`timescale 1ns / 1ps
package mli_pkg;

  // field and datapath widths
  parameter int InW       = 16;
  parameter int DiffW     = 17;
  parameter int ProdW     = 32;
  parameter int DetW      = 33;
  parameter int DenProdW  = 34;
  parameter int DenW      = 35;
  parameter int NumW      = 50;
  parameter int DivN      = 49;
  parameter int DenMagW   = 34;
  parameter int QuoW      = 50;
  parameter int SumW      = 52;
  parameter int MagW      = 25;
  parameter int OutW      = 24;
  parameter int NumLanes  = 3;
  parameter int NumAxes   = 2;

  // divide by three as multiply by ceil(2^26 / 3), exact below 2^25
  parameter int RecipShift = 26;
  parameter logic [MagW-1:0] Recip3 = 25'd22369622;

  // sums outside these bounds saturate after the divide by three
  parameter logic signed [SumW-1:0] SumSatHi = 52'sd25165824;
  parameter logic signed [SumW-1:0] SumSatLo = -52'sd25165827;
  parameter logic signed [OutW-1:0] OutMax = 24'sd8388607;
  parameter logic signed [OutW-1:0] OutMin = -24'sd8388608;

  // register stages: 4 in the lane front end, DivN + 1 in the divider, 4 in the merge
  parameter int PipeDepth = 4 + DivN + 1 + 4;

  typedef struct packed {
    logic signed [InW-1:0] start_x;
    logic signed [InW-1:0] start_y;
    logic signed [InW-1:0] end_x;
    logic signed [InW-1:0] end_y;
  } line_t;

  typedef struct packed {
    logic signed [QuoW-1:0] quo_x;
    logic signed [QuoW-1:0] quo_y;
    logic                   par;
  } lane_res_t;

endpackage

// File: sv/mli_div.sv
// pipelined restoring divider, one quotient bit per stage, truncating toward zero
`timescale 1ns / 1ps
module mli_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [mli_pkg::NumW-1:0] num_i,
  input  logic signed [mli_pkg::DenW-1:0] den_i,
  input  logic                           tag_i,
  output logic signed [mli_pkg::QuoW-1:0] quo_o,
  output logic                           tag_o
);

  logic [mli_pkg::DivN-1:0]    num_q [0:mli_pkg::DivN];
  logic [mli_pkg::DenMagW-1:0] rem_q [0:mli_pkg::DivN];
  logic [mli_pkg::DenMagW-1:0] den_q [0:mli_pkg::DivN];
  logic                        neg_q [0:mli_pkg::DivN];
  logic                        tag_q [0:mli_pkg::DivN];

  logic signed [mli_pkg::NumW-1:0] num_abs;
  logic signed [mli_pkg::DenW-1:0] den_abs;
  logic        [mli_pkg::QuoW-1:0] quo_mag;

  // magnitudes into the first stage
  always_comb begin
    num_abs = num_i[mli_pkg::NumW-1] ? -num_i : num_i;
    den_abs = den_i[mli_pkg::DenW-1] ? -den_i : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_abs[mli_pkg::DivN-1:0];
      rem_q[0] <= '0;
      den_q[0] <= den_abs[mli_pkg::DenMagW-1:0];
      neg_q[0] <= num_i[mli_pkg::NumW-1] ^ den_i[mli_pkg::DenW-1];
      tag_q[0] <= tag_i;
    end
  end

  // one trial subtract per stage
  for (genvar i = 0; i < mli_pkg::DivN; i++) begin : g_step
    logic [mli_pkg::DenMagW:0] trial;
    logic [mli_pkg::DenMagW:0] diff;
    logic                      ge;

    always_comb begin
      trial = {rem_q[i], num_q[i][mli_pkg::DivN-1]};
      diff  = trial - {1'b0, den_q[i]};
      ge    = trial >= {1'b0, den_q[i]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? diff[mli_pkg::DenMagW-1:0] : trial[mli_pkg::DenMagW-1:0];
        num_q[i+1] <= {num_q[i][mli_pkg::DivN-2:0], ge};
        den_q[i+1] <= den_q[i];
        neg_q[i+1] <= neg_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  // restore the sign
  always_comb begin
    quo_mag = {1'b0, num_q[mli_pkg::DivN]};
    quo_o   = neg_q[mli_pkg::DivN] ? -$signed(quo_mag) : $signed(quo_mag);
    tag_o   = tag_q[mli_pkg::DivN];
  end

endmodule

// File: sv/mli_lane.sv
// one line pair: determinants, numerators and denominator, then two dividers
`timescale 1ns / 1ps
module mli_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  mli_pkg::line_t     line_p_i,
  input  mli_pkg::line_t     line_q_i,
  output mli_pkg::lane_res_t res_o
);

  // stage 1: cross products and endpoint differences
  logic signed [mli_pkg::ProdW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [mli_pkg::DiffW-1:0] dx1_q, dy1_q, dx2_q, dy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= line_p_i.start_x * line_p_i.end_y;
      pb_q  <= line_p_i.start_y * line_p_i.end_x;
      pc_q  <= line_q_i.start_x * line_q_i.end_y;
      pd_q  <= line_q_i.start_y * line_q_i.end_x;
      dx1_q <= mli_pkg::DiffW'(line_p_i.start_x) - mli_pkg::DiffW'(line_p_i.end_x);
      dy1_q <= mli_pkg::DiffW'(line_p_i.start_y) - mli_pkg::DiffW'(line_p_i.end_y);
      dx2_q <= mli_pkg::DiffW'(line_q_i.start_x) - mli_pkg::DiffW'(line_q_i.end_x);
      dy2_q <= mli_pkg::DiffW'(line_q_i.start_y) - mli_pkg::DiffW'(line_q_i.end_y);
    end
  end

  // stage 2: determinants and denominator products
  logic signed [mli_pkg::DetW-1:0]     d1_q, d2_q;
  logic signed [mli_pkg::DenProdW-1:0] dena_q, denb_q;
  logic signed [mli_pkg::DiffW-1:0]    dx1_2q, dy1_2q, dx2_2q, dy2_2q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= mli_pkg::DetW'(pa_q) - mli_pkg::DetW'(pb_q);
      d2_q   <= mli_pkg::DetW'(pc_q) - mli_pkg::DetW'(pd_q);
      dena_q <= dx1_q * dy2_q;
      denb_q <= dy1_q * dx2_q;
      dx1_2q <= dx1_q;
      dy1_2q <= dy1_q;
      dx2_2q <= dx2_q;
      dy2_2q <= dy2_q;
    end
  end

  // stage 3: denominator and numerator products
  logic signed [mli_pkg::DenW-1:0] den_q;
  logic signed [mli_pkg::NumW-1:0] nxa_q, nxb_q, nya_q, nyb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= mli_pkg::DenW'(dena_q) - mli_pkg::DenW'(denb_q);
      nxa_q <= d1_q * dx2_2q;
      nxb_q <= dx1_2q * d2_q;
      nya_q <= d1_q * dy2_2q;
      nyb_q <= dy1_2q * d2_q;
    end
  end

  // stage 4: numerators and parallel test
  logic signed [mli_pkg::NumW-1:0] nx_q, ny_q;
  logic signed [mli_pkg::DenW-1:0] den_4q;
  logic                            par_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= nxa_q - nxb_q;
      ny_q   <= nya_q - nyb_q;
      den_4q <= den_q;
      par_q  <= (den_q == '0);
    end
  end

  // quotient for each axis
  logic unused_tag;

  mli_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (nx_q),
    .den_i (den_4q),
    .tag_i (par_q),
    .quo_o (res_o.quo_x),
    .tag_o (res_o.par)
  );

  mli_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (ny_q),
    .den_i (den_4q),
    .tag_i (1'b0),
    .quo_o (res_o.quo_y),
    .tag_o (unused_tag)
  );

endmodule

// File: sv/mli_merge.sv
// merge of the three lanes: sum, saturation test, divide by three, output register
`timescale 1ns / 1ps
module mli_merge (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  mli_pkg::lane_res_t              res_i [mli_pkg::NumLanes],
  output logic signed [mli_pkg::OutW-1:0] mean_x_o,
  output logic signed [mli_pkg::OutW-1:0] mean_y_o,
  output logic                            par_o
);

  logic signed [mli_pkg::QuoW-1:0] quo [mli_pkg::NumAxes][mli_pkg::NumLanes];

  always_comb begin
    for (int l = 0; l < mli_pkg::NumLanes; l++) begin
      quo[0][l] = res_i[l].quo_x;
      quo[1][l] = res_i[l].quo_y;
    end
  end

  logic par_a_q, par_b_q, par_c_q, par_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_a_q <= res_i[0].par | res_i[1].par | res_i[2].par;
      par_b_q <= par_a_q;
      par_c_q <= par_b_q;
      par_d_q <= par_c_q;
    end
  end

  logic signed [mli_pkg::OutW-1:0] mean_q [mli_pkg::NumAxes];

  for (genvar a = 0; a < mli_pkg::NumAxes; a++) begin : g_axis
    logic signed [mli_pkg::SumW-1:0]   sum_q;
    logic signed [mli_pkg::SumW-1:0]   abs_d;
    logic        [mli_pkg::MagW-1:0]   mag_q;
    logic                              neg_q, hi_q, lo_q, neg_c_q, hi_c_q, lo_c_q;
    logic        [2*mli_pkg::MagW-1:0] prod_q;
    logic        [mli_pkg::OutW-1:0]   div_d;
    logic signed [mli_pkg::OutW-1:0]   mean_d;

    // sum of the three quotients
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q <= mli_pkg::SumW'(quo[a][0]) + mli_pkg::SumW'(quo[a][1])
               + mli_pkg::SumW'(quo[a][2]);
      end
    end

    // saturation test and magnitude
    always_comb begin
      abs_d = sum_q[mli_pkg::SumW-1] ? -sum_q : sum_q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hi_q  <= sum_q >= mli_pkg::SumSatHi;
        lo_q  <= sum_q <= mli_pkg::SumSatLo;
        neg_q <= sum_q[mli_pkg::SumW-1];
        mag_q <= abs_d[mli_pkg::MagW-1:0];
      end
    end

    // divide by three through the reciprocal
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q  <= mag_q * mli_pkg::Recip3;
        neg_c_q <= neg_q;
        hi_c_q  <= hi_q;
        lo_c_q  <= lo_q;
      end
    end

    // sign, saturation and parallel override
    always_comb begin
      div_d = prod_q[mli_pkg::RecipShift+mli_pkg::OutW-1:mli_pkg::RecipShift];
      if (par_c_q) begin
        mean_d = '0;
      end else if (hi_c_q) begin
        mean_d = mli_pkg::OutMax;
      end else if (lo_c_q) begin
        mean_d = mli_pkg::OutMin;
      end else if (neg_c_q) begin
        mean_d = -$signed(div_d);
      end else begin
        mean_d = $signed(div_d);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mean_q[a] <= mean_d;
      end
    end
  end

  assign mean_x_o = mean_q[0];
  assign mean_y_o = mean_q[1];
  assign par_o    = par_d_q;

endmodule

// File: sv/mean_line_intersection_core.sv
// mean of the pairwise intersections of three lines, one lane per line pair
// register stages from input transfer to result valid: 4 front end, 50 divider, 4 merge
// throughput: one item per cycle; the 50-stage divider in each lane accepts a new item each cycle
// the whole pipeline holds while a result waits and out_ready_i is low
// reset: asynchronous, active low, clears the valid bits of every stage; data is not reset
`timescale 1ns / 1ps
module mean_line_intersection_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [mli_pkg::InW-1:0]  line_a_start_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_a_start_y_i,
  input  logic signed [mli_pkg::InW-1:0]  line_a_end_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_a_end_y_i,
  input  logic signed [mli_pkg::InW-1:0]  line_b_start_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_b_start_y_i,
  input  logic signed [mli_pkg::InW-1:0]  line_b_end_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_b_end_y_i,
  input  logic signed [mli_pkg::InW-1:0]  line_c_start_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_c_start_y_i,
  input  logic signed [mli_pkg::InW-1:0]  line_c_end_x_i,
  input  logic signed [mli_pkg::InW-1:0]  line_c_end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [mli_pkg::OutW-1:0] mean_x_o,
  output logic signed [mli_pkg::OutW-1:0] mean_y_o,
  output logic                            parallel_flag_o
);

  mli_pkg::line_t     line_a, line_b, line_c;
  mli_pkg::lane_res_t lane_res [mli_pkg::NumLanes];
  logic               en;
  logic               valid_q [0:mli_pkg::PipeDepth-1];

  assign line_a = '{line_a_start_x_i, line_a_start_y_i, line_a_end_x_i, line_a_end_y_i};
  assign line_b = '{line_b_start_x_i, line_b_start_y_i, line_b_end_x_i, line_b_end_y_i};
  assign line_c = '{line_c_start_x_i, line_c_start_y_i, line_c_end_x_i, line_c_end_y_i};

  // pipeline moves unless the output holds an untaken result
  assign en          = !valid_q[mli_pkg::PipeDepth-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[mli_pkg::PipeDepth-1];

  // valid bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < mli_pkg::PipeDepth; s++) valid_q[s] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int s = 1; s < mli_pkg::PipeDepth; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  // lanes for the pairs (a,b), (a,c), (b,c)
  mli_lane u_lane_ab (
    .clk_i    (clk_i),
    .en_i     (en),
    .line_p_i (line_a),
    .line_q_i (line_b),
    .res_o    (lane_res[0])
  );

  mli_lane u_lane_ac (
    .clk_i    (clk_i),
    .en_i     (en),
    .line_p_i (line_a),
    .line_q_i (line_c),
    .res_o    (lane_res[1])
  );

  mli_lane u_lane_bc (
    .clk_i    (clk_i),
    .en_i     (en),
    .line_p_i (line_b),
    .line_q_i (line_c),
    .res_o    (lane_res[2])
  );

  mli_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .res_i    (lane_res),
    .mean_x_o (mean_x_o),
    .mean_y_o (mean_y_o),
    .par_o    (parallel_flag_o)
  );

  // checks
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parallel_flag_o |-> mean_x_o == '0 && mean_y_o == '0)
    else $error("parallel result carries a nonzero mean");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("transfer lost at pipeline entry");

endmodule

// File: tb/sv/tb_mean_line_intersection_core.sv
// self-checking testbench for the mean line intersection core
`timescale 1ns / 1ps
module tb_mean_line_intersection_core;

  typedef struct packed {
    mli_pkg::line_t la;
    mli_pkg::line_t lb;
    mli_pkg::line_t lc;
  } line_set_t;

  typedef struct packed {
    logic signed [mli_pkg::OutW-1:0] mx;
    logic signed [mli_pkg::OutW-1:0] my;
    logic                            par;
  } mean_pt_t;

  localparam int MaxCycles = 3000000;
  localparam int LongHold  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [mli_pkg::OutW-1:0] mean_x_o, mean_y_o;
  logic parallel_flag_o;
  line_set_t cur_set = '0;
  logic in_ready_q = 1'b0;

  line_set_t pending_sets[$];
  mean_pt_t expected_means[$];
  int unsigned mismatch_cnt = 0;
  int unsigned transfers_in = 0, transfers_out = 0, parallel_seen = 0;
  int unsigned send_idle_pct = 15, recv_idle_pct = 83;
  bit hold_start = 1'b0;
  bit hold_off = 1'b0;
  bit pause_send = 1'b0;
  longint unsigned cycle_cnt = 0;

  always #2 clk_i = ~clk_i;

  mean_line_intersection_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .line_a_start_x_i(cur_set.la.start_x), .line_a_start_y_i(cur_set.la.start_y),
    .line_a_end_x_i(cur_set.la.end_x), .line_a_end_y_i(cur_set.la.end_y),
    .line_b_start_x_i(cur_set.lb.start_x), .line_b_start_y_i(cur_set.lb.start_y),
    .line_b_end_x_i(cur_set.lb.end_x), .line_b_end_y_i(cur_set.lb.end_y),
    .line_c_start_x_i(cur_set.lc.start_x), .line_c_start_y_i(cur_set.lc.start_y),
    .line_c_end_x_i(cur_set.lc.end_x), .line_c_end_y_i(cur_set.lc.end_y),
    .out_valid_o, .out_ready_i, .mean_x_o, .mean_y_o, .parallel_flag_o
  );

  // intersect one pair of lines; returns 0 when the pair is parallel
  function automatic bit pair_cross(mli_pkg::line_t p, mli_pkg::line_t q, output longint qx,
                                    output longint qy);
    longint x1, y1, x2, y2, x3, y3, x4, y4, d1, d2, nx, ny, den;
    x1 = p.start_x; y1 = p.start_y; x2 = p.end_x; y2 = p.end_y;
    x3 = q.start_x; y3 = q.start_y; x4 = q.end_x; y4 = q.end_y;
    d1 = x1 * y2 - y1 * x2;
    d2 = x3 * y4 - y3 * x4;
    nx = d1 * (x3 - x4) - (x1 - x2) * d2;
    ny = d1 * (y3 - y4) - (y1 - y2) * d2;
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    qx = 0;
    qy = 0;
    if (den == 0) return 1'b0;
    qx = nx / den;
    qy = ny / den;
    return 1'b1;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > longint'(mli_pkg::OutMax)) return longint'(mli_pkg::OutMax);
    if (v < longint'(mli_pkg::OutMin)) return longint'(mli_pkg::OutMin);
    return v;
  endfunction

  // expected mean of the three pairwise intersections
  function automatic mean_pt_t mean_of_crossings(line_set_t s);
    mean_pt_t r;
    longint qx, qy, sx, sy;
    bit ok;
    sx = 0;
    sy = 0;
    ok = 1'b1;
    if (pair_cross(s.la, s.lb, qx, qy)) begin sx += qx; sy += qy; end else ok = 1'b0;
    if (pair_cross(s.la, s.lc, qx, qy)) begin sx += qx; sy += qy; end else ok = 1'b0;
    if (pair_cross(s.lb, s.lc, qx, qy)) begin sx += qx; sy += qy; end else ok = 1'b0;
    r = '0;
    if (!ok) begin
      r.par = 1'b1;
    end else begin
      r.mx = mli_pkg::OutW'(clamp24(sx / 3));
      r.my = mli_pkg::OutW'(clamp24(sy / 3));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // append a line set to the pending stimulus
  task automatic queue_set(line_set_t s);
    pending_sets.insert(pending_sets.size(), s);
  endtask

  function automatic logic [15:0] rnd_coord(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return $urandom_range(1, 0) ? 16'h7fff - 16'($urandom_range(0, 3))
                                           : 16'h8000 + 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic mli_pkg::line_t rnd_line(int unsigned mode);
    mli_pkg::line_t l;
    l.start_x = rnd_coord(mode); l.start_y = rnd_coord(mode);
    l.end_x = rnd_coord(mode); l.end_y = rnd_coord(mode);
    return l;
  endfunction

  function automatic mli_pkg::line_t mk_line(int sx, int sy, int ex, int ey);
    mli_pkg::line_t l;
    l.start_x = 16'(sx); l.start_y = 16'(sy); l.end_x = 16'(ex); l.end_y = 16'(ey);
    return l;
  endfunction

  function automatic line_set_t rnd_set();
    line_set_t s;
    int unsigned m;
    m = $urandom_range(0, 9);
    s.la = rnd_line(m < 5 ? 0 : (m < 8 ? 1 : 2));
    s.lb = rnd_line(m < 5 ? 0 : (m < 8 ? 1 : 2));
    s.lc = rnd_line(m < 5 ? 0 : (m < 8 ? 1 : 2));
    // occasionally make a pair parallel or a line degenerate
    if ($urandom_range(0, 19) == 0) s.lc = s.la;
    if ($urandom_range(0, 29) == 0) begin
      s.lb.end_x = s.lb.start_x; s.lb.end_y = s.lb.start_y;
    end
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_sets.size() != 0 || in_valid_i || expected_means.size() != 0)
      @(posedge clk_i);
  endtask

  // driver: offer items at the falling edge, hold until transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_q) begin
        if (pending_sets.size() != 0 && !pause_send &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          cur_set <= pending_sets.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted in cycles here
  initial begin
    wait (hold_start);
    hold_off = 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // transfer on the input side seen at the rising edge
  always @(posedge clk_i) begin
    in_ready_q <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_means.insert(expected_means.size(), mean_of_crossings(cur_set));
      transfers_in++;
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    mean_pt_t want;
    cycle_cnt++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      transfers_out++;
      if (expected_means.size() == 0) begin
        report_mismatch("unexpected result, mean_x", mean_x_o, 0);
      end else begin
        want = expected_means.pop_front();
        if (parallel_flag_o) parallel_seen++;
        if (parallel_flag_o !== want.par) report_mismatch("parallel_flag", parallel_flag_o, want.par);
        if (mean_x_o !== want.mx) report_mismatch("mean_x", mean_x_o, want.mx);
        if (mean_y_o !== want.my) report_mismatch("mean_y", mean_y_o, want.my);
      end
    end
    if (cycle_cnt > MaxCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    line_set_t s;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: simple triangle, extremes, parallel and degenerate lines
    s.la = mk_line(0, 0, 160, 0); s.lb = mk_line(0, 0, 0, 160);
    s.lc = mk_line(160, 0, 0, 160); queue_set(s);
    s.la = mk_line(-32768, -32768, 32767, 32767); s.lb = mk_line(-32768, 32767, 32767, -32768);
    s.lc = mk_line(-32768, 0, 32767, 1); queue_set(s);
    s.la = mk_line(32767, -32768, -32768, 32767); s.lb = mk_line(32767, 32767, 32766, -32768);
    s.lc = mk_line(-32768, -32768, -32767, 32767); queue_set(s);
    s.la = mk_line(0, 0, 1, 0); s.lb = mk_line(0, 1, 1, 1);
    s.lc = mk_line(0, 0, 0, 1); queue_set(s);
    s.la = mk_line(5, 5, 5, 5); s.lb = mk_line(0, 0, 0, 10);
    s.lc = mk_line(0, 0, 10, 0); queue_set(s);
    s.la = mk_line(-1, -1, 0, 0); s.lb = mk_line(-1, 0, 0, -1);
    s.lc = mk_line(-1, -1, 0, -1); queue_set(s);
    // nearly parallel lines far from the origin to drive saturation
    s.la = mk_line(-32768, 0, 32767, 1); s.lb = mk_line(-32768, 1, 32767, 1);
    s.lc = mk_line(0, -32768, 1, 32767); queue_set(s);
    s.la = mk_line(-32768, 0, 32767, -1); s.lb = mk_line(-32768, -1, 32767, -1);
    s.lc = mk_line(0, 32767, -1, -32768); queue_set(s);
    s.la = '1; s.lb = '0; s.lc = mk_line(-1, 0, 0, -1); queue_set(s);
    for (int i = 0; i < 440; i++) queue_set(rnd_set());

    // long receiver hold-off while the sender keeps offering
    @(negedge clk_i);
    hold_start = 1'b1;
    wait_drained();

    send_idle_pct = 83; recv_idle_pct = 15;
    for (int i = 0; i < 450; i++) queue_set(rnd_set());
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 450; i++) queue_set(rnd_set());
    wait_drained();

    // sender pause until all results are back, then a short burst
    pause_send = 1'b1;
    repeat (mli_pkg::PipeDepth + 10) @(posedge clk_i);
    pause_send = 1'b0;
    for (int i = 0; i < 10; i++) queue_set(rnd_set());
    wait_drained();
    repeat (mli_pkg::PipeDepth + 10) @(posedge clk_i);

    $display("Sent %0d line sets, checked %0d results (%0d parallel)",
             transfers_in, transfers_out, parallel_seen);
    $display("Covered field extremes, parallel and degenerate lines, saturation and stalls");
    if (mismatch_cnt == 0 && expected_means.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
